[rtl/degree_weighted_sum_tree_sampler_assert.svh]
// Assertion macros for the degree weighted sum tree sampler.
`ifndef DEGREE_WEIGHTED_SUM_TREE_SAMPLER_ASSERT_SVH
`define DEGREE_WEIGHTED_SUM_TREE_SAMPLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DWST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dwst check failed");

// Next-cycle implication, checked outside reset.
`define DWST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dwst check failed");

`endif

[rtl/dwst_pkg.sv]
// Types and constants of the degree weighted sum tree sampler.
`default_nettype none

package dwst_pkg;

    localparam int DEGREES_DEF    = 64;
    localparam int BUCKET_CAP_DEF = 256;
    localparam int NODE_BITS_DEF  = 16;

    localparam logic [1:0] MODE_SET_WEIGHT = 2'd0;
    localparam logic [1:0] MODE_ADD_NODE   = 2'd1;
    localparam logic [1:0] MODE_DRAW       = 2'd2;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_TREE_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_BUCKET_FULL = 2'd2;

    localparam int PICK_W = 16;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_W_RD,
        ST_W_CNT,
        ST_A_RD,
        ST_A_CHK,
        ST_MUL_W,
        ST_LEAF,
        ST_UP_RD,
        ST_UP_ADD,
        ST_D_ROOT,
        ST_D_MUL,
        ST_D_TGT,
        ST_D_L,
        ST_D_R,
        ST_D_DEC,
        ST_P_CNT,
        ST_P_DIV0,
        ST_P_DIV,
        ST_P_RD1,
        ST_P_RD2,
        ST_P_WR,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

[rtl/degree_weighted_sum_tree_sampler.sv]
// Degree bucketed weighted sampler without replacement on a binary sum tree.
//
// Input stream s_*: one beat per command (set weight, add node, draw node).
// Output stream m_*: exactly one result beat per command, in order.
// Config channel cfg_*: sets greedy_mode; always ready, write only when idle.
// One command is worked on at a time; s_tready is high only when the
// sequencer is idle. All tree, weight, count and node accesses go through
// single-port memories and one shared multiplier; a command runs through:
//   set weight / add node : reads, product, leaf write, path rewrite
//   draw                  : root read and scaling, descent per level,
//                           16-step remainder, node swap, path rewrite
//   empty draw / full add : straight to the result; unused mode likewise
// The result sits in an output register; the next command is accepted while
// it waits, and its own result stalls until the receiver takes the first.
// After reset a clearing pass over every tree entry zeroes the tree, weights
// and counts; s_tready stays low meanwhile.
`default_nettype none

module degree_weighted_sum_tree_sampler
    import dwst_pkg::*;
#(
    parameter int DEGREES    = DEGREES_DEF,
    parameter int BUCKET_CAP = BUCKET_CAP_DEF,
    parameter int NODE_BITS  = NODE_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // mode[1:0], degree[7:2], weight[23:8], node_id[39:24],
    // random_fraction[71:40], random_pick[87:72]
    input  wire logic [87:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // status[1:0], drawn_node[17:2], drawn_degree[23:18]
    output logic [23:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);

    localparam int TW    = $clog2(2 * DEGREES);
    localparam int DW    = $clog2(DEGREES);
    localparam int CNT_W = $clog2(BUCKET_CAP + 1);
    localparam int RW    = CNT_W + 1;
    localparam int NA    = $clog2(DEGREES * BUCKET_CAP);

    // memories
    logic [31:0]          tree_mem [2*DEGREES];
    logic [15:0]          wt_mem   [DEGREES];
    logic [CNT_W-1:0]     cnt_mem  [DEGREES];
    logic [NODE_BITS-1:0] node_mem [DEGREES*BUCKET_CAP];

    logic                 tree_we, tree_re;
    logic [TW-1:0]        tree_waddr, tree_raddr;
    logic [31:0]          tree_wdata, tree_rd_reg;
    logic                 wt_we, wt_re;
    logic [DW-1:0]        wt_waddr, wt_raddr;
    logic [15:0]          wt_wdata, wt_rd_reg;
    logic                 cnt_we, cnt_re;
    logic [DW-1:0]        cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]     cnt_wdata, cnt_rd_reg;
    logic                 node_we, node_re;
    logic [NA-1:0]        node_waddr, node_raddr;
    logic [NODE_BITS-1:0] node_wdata, node_rd_reg;

    state_t state_reg, state_next;
    logic [TW-1:0]        clr_reg, clr_next;
    logic                 greedy_reg;
    logic [1:0]           mode_reg, mode_next;
    logic [DW-1:0]        deg_reg, deg_next;
    logic [15:0]          wt_in_reg, wt_in_next;
    logic [NODE_BITS-1:0] node_in_reg, node_in_next;
    logic [31:0]          frac_reg, frac_next;
    logic [PICK_W-1:0]    pick_reg, pick_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [63:0]          prod_reg, prod_next;
    logic [31:0]          val_reg, val_next;
    logic [TW-1:0]        p_reg, p_next;
    logic [31:0]          tgt_reg, tgt_next;
    logic [31:0]          l_reg, l_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [3:0]           div_cnt_reg, div_cnt_next;
    logic [NODE_BITS-1:0] dnode_reg, dnode_next;
    logic [1:0]           status_reg, status_next;
    logic                 m_valid_reg, m_valid_next;
    logic [23:0]          m_data_reg, m_data_next;

    logic                 s_accept;
    logic [1:0]           in_mode;
    logic [5:0]           in_degree;
    logic [DW-1:0]        in_deg_sat;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_p;
    logic                 go_right;
    logic [TW-1:0]        idx_dn;
    logic [31:0]          tgt_dn;
    logic [32:0]          up_sum;
    logic [RW-1:0]        rem_sh;
    logic [NA-1:0]        bucket_base;
    logic                 out_free;
    logic                 draw_ok;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign in_mode   = s_tdata[1:0];
    assign in_degree = s_tdata[7:2];
    assign in_deg_sat = (32'(in_degree) >= DEGREES) ? DW'(DEGREES - 1) : DW'(in_degree);
    assign out_free  = !m_valid_reg || m_tready;

    // shared multiplier
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // descent decision: zero child skipped, greedy goes right
    assign go_right = (l_reg == 32'd0) ||
                      ((tree_rd_reg != 32'd0) && (greedy_reg || !(tgt_reg < l_reg)));
    assign idx_dn   = go_right ? ((p_reg << 1) | TW'(1)) : (p_reg << 1);
    assign tgt_dn   = !go_right ? tgt_reg :
                      ((tgt_reg >= l_reg) ? (tgt_reg - l_reg) : 32'd0);

    assign up_sum      = {1'b0, val_reg} + {1'b0, tree_rd_reg};
    assign rem_sh      = {rem_reg[CNT_W-1:0], pick_reg[PICK_W-1]};
    assign bucket_base = NA'(deg_reg) * NA'(BUCKET_CAP);
    assign draw_ok     = (mode_reg == MODE_DRAW) && (status_reg == STATUS_OK);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == TW'(2 * DEGREES - 1)) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    unique case (in_mode)
                        MODE_SET_WEIGHT: state_next = ST_W_RD;
                        MODE_ADD_NODE:   state_next = ST_A_RD;
                        MODE_DRAW:       state_next = ST_D_ROOT;
                        default:         state_next = ST_OUT;
                    endcase
                end
            end
            ST_W_RD:   state_next = ST_W_CNT;
            ST_W_CNT:  state_next = ST_MUL_W;
            ST_A_RD:   state_next = ST_A_CHK;
            ST_A_CHK:  state_next = (32'(cnt_rd_reg) >= BUCKET_CAP) ? ST_OUT : ST_MUL_W;
            ST_MUL_W:  state_next = ST_LEAF;
            ST_LEAF:   state_next = ST_UP_RD;
            ST_UP_RD:  state_next = (p_reg == TW'(1)) ? ST_OUT : ST_UP_ADD;
            ST_UP_ADD: state_next = ST_UP_RD;
            ST_D_ROOT: state_next = ST_D_MUL;
            ST_D_MUL:  state_next = (tree_rd_reg == 32'd0) ? ST_OUT : ST_D_TGT;
            ST_D_TGT:  state_next = ST_D_L;
            ST_D_L:    state_next = ST_D_R;
            ST_D_R:    state_next = ST_D_DEC;
            ST_D_DEC:  state_next = (idx_dn >= TW'(DEGREES)) ? ST_P_CNT : ST_D_L;
            ST_P_CNT:  state_next = ST_P_DIV0;
            ST_P_DIV0: state_next = (cnt_rd_reg == '0) ? ST_OUT : ST_P_DIV;
            ST_P_DIV:  state_next = (div_cnt_reg == 4'(PICK_W - 1)) ? ST_P_RD1 : ST_P_DIV;
            ST_P_RD1:  state_next = ST_P_RD2;
            ST_P_RD2:  state_next = ST_P_WR;
            ST_P_WR:   state_next = ST_MUL_W;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        clr_next     = clr_reg;
        mode_next    = mode_reg;
        deg_next     = deg_reg;
        wt_in_next   = wt_in_reg;
        node_in_next = node_in_reg;
        frac_next    = frac_reg;
        pick_next    = pick_reg;
        cnt_next     = cnt_reg;
        prod_next    = prod_reg;
        val_next     = val_reg;
        p_next       = p_reg;
        tgt_next     = tgt_reg;
        l_next       = l_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        dnode_next   = dnode_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        mul_a        = 32'(wt_rd_reg);
        mul_b        = 32'(cnt_reg);
        tree_we = 1'b0; tree_waddr = '0; tree_wdata = '0;
        tree_re = 1'b0; tree_raddr = '0;
        wt_we   = 1'b0; wt_waddr   = deg_reg; wt_wdata = wt_in_reg;
        wt_re   = 1'b0; wt_raddr   = deg_reg;
        cnt_we  = 1'b0; cnt_waddr  = deg_reg; cnt_wdata = '0;
        cnt_re  = 1'b0; cnt_raddr  = deg_reg;
        node_we = 1'b0; node_waddr = '0; node_wdata = node_in_reg;
        node_re = 1'b0; node_raddr = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                tree_we    = 1'b1;
                tree_waddr = clr_reg;
                if (clr_reg < TW'(DEGREES))
                begin
                    wt_we     = 1'b1;
                    wt_waddr  = DW'(clr_reg);
                    wt_wdata  = '0;
                    cnt_we    = 1'b1;
                    cnt_waddr = DW'(clr_reg);
                end
                clr_next = clr_reg + TW'(1);
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    mode_next    = in_mode;
                    deg_next     = in_deg_sat;
                    wt_in_next   = s_tdata[23:8];
                    node_in_next = NODE_BITS'(s_tdata[39:24]);
                    frac_next    = s_tdata[71:40];
                    pick_next    = s_tdata[87:72];
                    status_next  = STATUS_OK;
                    dnode_next   = '0;
                end
            end
            ST_W_RD:
            begin
                wt_we  = 1'b1;
                cnt_re = 1'b1;
            end
            ST_W_CNT:
            begin
                cnt_next = cnt_rd_reg;
                wt_re    = 1'b1;
            end
            ST_A_RD:   cnt_re = 1'b1;
            ST_A_CHK:
            begin
                if (32'(cnt_rd_reg) >= BUCKET_CAP)
                begin
                    status_next = STATUS_BUCKET_FULL;
                end
                else
                begin
                    node_we    = 1'b1;
                    node_waddr = bucket_base + NA'(cnt_rd_reg);
                    cnt_we     = 1'b1;
                    cnt_wdata  = cnt_rd_reg + CNT_W'(1);
                    cnt_next   = cnt_rd_reg + CNT_W'(1);
                    wt_re      = 1'b1;
                end
            end
            ST_MUL_W:  prod_next = mul_p;
            ST_LEAF:
            begin
                if (deg_reg == '0)
                    val_next = '0;
                else if (prod_reg[63:32] != 32'd0)
                    val_next = 32'hFFFF_FFFF;
                else
                    val_next = prod_reg[31:0];
                tree_we    = 1'b1;
                tree_waddr = TW'(DEGREES) + TW'(deg_reg);
                tree_wdata = val_next;
                p_next     = TW'(DEGREES) + TW'(deg_reg);
            end
            ST_UP_RD:
            begin
                tree_re    = (p_reg != TW'(1));
                tree_raddr = p_reg ^ TW'(1);
            end
            ST_UP_ADD:
            begin
                val_next   = up_sum[32] ? 32'hFFFF_FFFF : up_sum[31:0];
                tree_we    = 1'b1;
                tree_waddr = p_reg >> 1;
                tree_wdata = val_next;
                p_next     = p_reg >> 1;
            end
            ST_D_ROOT:
            begin
                tree_re    = 1'b1;
                tree_raddr = TW'(1);
            end
            ST_D_MUL:
            begin
                mul_a     = frac_reg;
                mul_b     = tree_rd_reg;
                prod_next = mul_p;
                p_next    = TW'(1);
                if (tree_rd_reg == 32'd0) status_next = STATUS_TREE_EMPTY;
            end
            ST_D_TGT:  tgt_next = prod_reg[63:32];
            ST_D_L:
            begin
                tree_re    = 1'b1;
                tree_raddr = p_reg << 1;
            end
            ST_D_R:
            begin
                tree_re    = 1'b1;
                tree_raddr = (p_reg << 1) | TW'(1);
                l_next     = tree_rd_reg;
            end
            ST_D_DEC:
            begin
                tgt_next = tgt_dn;
                p_next   = idx_dn;
                deg_next = DW'(idx_dn - TW'(DEGREES));
            end
            ST_P_CNT:  cnt_re = 1'b1;
            ST_P_DIV0:
            begin
                cnt_next     = cnt_rd_reg;
                rem_next     = '0;
                div_cnt_next = '0;
                if (cnt_rd_reg == '0) status_next = STATUS_TREE_EMPTY;
            end
            ST_P_DIV:
            begin
                // restoring remainder, one pick bit per cycle
                rem_next     = (rem_sh >= RW'(cnt_reg)) ? (rem_sh - RW'(cnt_reg)) : rem_sh;
                pick_next    = pick_reg << 1;
                div_cnt_next = div_cnt_reg + 4'd1;
            end
            ST_P_RD1:
            begin
                node_re    = 1'b1;
                node_raddr = bucket_base + NA'(rem_reg[CNT_W-1:0]);
            end
            ST_P_RD2:
            begin
                node_re    = 1'b1;
                node_raddr = bucket_base + NA'(cnt_reg - CNT_W'(1));
                dnode_next = node_rd_reg;
            end
            ST_P_WR:
            begin
                // swap-with-last: last entry moves into the drawn slot
                node_we    = 1'b1;
                node_waddr = bucket_base + NA'(rem_reg[CNT_W-1:0]);
                node_wdata = node_rd_reg;
                cnt_we     = 1'b1;
                cnt_wdata  = cnt_reg - CNT_W'(1);
                cnt_next   = cnt_reg - CNT_W'(1);
                wt_re      = 1'b1;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {draw_ok ? 6'(deg_reg) : 6'd0,
                                    draw_ok ? 16'(dnode_reg) : 16'd0,
                                    status_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            greedy_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) greedy_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        deg_reg     <= deg_next;
        wt_in_reg   <= wt_in_next;
        node_in_reg <= node_in_next;
        frac_reg    <= frac_next;
        pick_reg    <= pick_next;
        cnt_reg     <= cnt_next;
        prod_reg    <= prod_next;
        val_reg     <= val_next;
        p_reg       <= p_next;
        tgt_reg     <= tgt_next;
        l_reg       <= l_next;
        rem_reg     <= rem_next;
        div_cnt_reg <= div_cnt_next;
        dnode_reg   <= dnode_next;
        status_reg  <= status_next;
        m_data_reg  <= m_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (tree_we) tree_mem[tree_waddr] <= tree_wdata;
        if (tree_re) tree_rd_reg <= tree_mem[tree_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (wt_we) wt_mem[wt_waddr] <= wt_wdata;
        if (wt_re) wt_rd_reg <= wt_mem[wt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
        if (cnt_re) cnt_rd_reg <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (node_we) node_mem[node_waddr] <= node_wdata;
        if (node_re) node_rd_reg <= node_mem[node_raddr];
    end

`include "degree_weighted_sum_tree_sampler_assert.svh"

    `DWST_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `DWST_ASSERT_IMP(a_fail_no_node, m_tvalid && (m_tdata[1:0] != STATUS_OK), m_tdata[23:2] == '0)
    `DWST_ASSERT_IMP(a_descend_inner, state_reg == ST_D_DEC, p_reg < TW'(DEGREES))

endmodule

`default_nettype wire

[dv/degree_weighted_sum_tree_sampler_tb.sv]
// Testbench for the degree weighted sum tree sampler: directed and random commands.
`timescale 1ns / 100ps

module degree_weighted_sum_tree_sampler_tb
    import dwst_pkg::*;
();

    localparam int NDEG      = 64;
    localparam int CAP       = 256;
    localparam int WDOG_MAX  = 20000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // packed from the top bit down: degree[23:18], node[17:2], status[1:0]
    typedef struct packed {
        logic [5:0]  degree;
        logic [15:0] node;
        logic [1:0]  status;
    } draw_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    degree_weighted_sum_tree_sampler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // mirror of the sampler state
    logic [31:0] tree_sum [1:2*NDEG-1];
    logic [15:0] deg_weight [NDEG];
    int unsigned deg_count [NDEG];
    logic [15:0] bucket_ids [NDEG][CAP];
    logic        greedy;

    draw_result_t pending_results[$];
    int          error_count;
    int          draws_ok;
    int          draws_empty;
    int          adds_full;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    int          quiet_cycles;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void rebuild_path(int d);
        logic [63:0] v;
        int p;
        v = 64'd0;
        if (d != 0 && deg_count[d] != 0)
            v = deg_weight[d] * 64'(deg_count[d]);
        p = NDEG + d;
        tree_sum[p] = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        while (p > 1)
        begin
            p = p >> 1;
            tree_sum[p] = sat_sum(tree_sum[2*p], tree_sum[2*p+1]);
        end
    endfunction

    function automatic draw_result_t apply_command(logic [87:0] cmd);
        draw_result_t res;
        logic [1:0]  mode;
        int          d;
        logic [63:0] prod;
        logic [31:0] target;
        logic [31:0] lsum;
        logic [31:0] rsum;
        int          idx;
        int          leaf;
        int          c;
        int          r;
        bit          go_right;
        res = '0;
        mode = cmd[1:0];
        d = int'(cmd[7:2]);
        case (mode)
            MODE_SET_WEIGHT:
            begin
                deg_weight[d] = cmd[23:8];
                rebuild_path(d);
            end
            MODE_ADD_NODE:
            begin
                if (deg_count[d] >= CAP)
                    res.status = STATUS_BUCKET_FULL;
                else
                begin
                    bucket_ids[d][deg_count[d]] = cmd[39:24];
                    deg_count[d]++;
                    rebuild_path(d);
                end
            end
            MODE_DRAW:
            begin
                if (tree_sum[1] == 0)
                    res.status = STATUS_TREE_EMPTY;
                else
                begin
                    prod = 64'(cmd[71:40]) * 64'(tree_sum[1]);
                    target = prod[63:32];
                    idx = 1;
                    while (idx < NDEG)
                    begin
                        lsum = tree_sum[2*idx];
                        rsum = tree_sum[2*idx+1];
                        if (lsum == 0)
                            go_right = 1'b1;
                        else if (rsum == 0)
                            go_right = 1'b0;
                        else if (greedy)
                            go_right = 1'b1;
                        else
                            go_right = !(target < lsum);
                        if (go_right)
                        begin
                            target = (target >= lsum) ? target - lsum : 32'd0;
                            idx = 2*idx + 1;
                        end
                        else
                            idx = 2*idx;
                    end
                    leaf = idx - NDEG;
                    c = deg_count[leaf];
                    if (c == 0)
                        res.status = STATUS_TREE_EMPTY;
                    else
                    begin
                        r = int'(cmd[87:72]) % c;
                        res.node = bucket_ids[leaf][r];
                        res.degree = 6'(leaf);
                        bucket_ids[leaf][r] = bucket_ids[leaf][c-1];
                        deg_count[leaf] = c - 1;
                        rebuild_path(leaf);
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_command(logic [1:0] mode, int d, logic [15:0] w, logic [15:0] id,
                                logic [31:0] frac, logic [15:0] pick);
        // valid drops after each beat; send_idle_pct adds random idle time
        @(posedge clk);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
            @(posedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {pick, frac, id, w, 6'(d), mode};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.insert(pending_results.size(),
                               apply_command({pick, frac, id, w, 6'(d), mode}));
        s_tvalid <= 1'b0;
    endtask

    // result checker, driven by m_tready randomization
    always @(posedge clk)
    begin
        draw_result_t got;
        draw_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (pending_results.size() == 0)
                    report_mismatch("unexpected beat", 32'(m_tdata), 32'd0);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.node != want.node)
                        report_mismatch("drawn_node", 32'(got.node), 32'(want.node));
                    if (got.degree != want.degree)
                        report_mismatch("drawn_degree", 32'(got.degree), 32'(want.degree));
                    if (want.status == STATUS_TREE_EMPTY)
                        draws_empty++;
                    else if (want.status == STATUS_BUCKET_FULL)
                        adds_full++;
                    else if (got.degree != 0 || got.node != 0)
                        draws_ok++;
                end
            end
            m_tready <= !hold_off &&
                        !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("Watchdog expired");
            $display("Verification failed");
            $finish;
        end
    end

    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_greedy(logic v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        greedy = v;
    endtask

    task automatic draw_random();
        send_command(MODE_DRAW, $urandom_range(63, 0), 16'($urandom), 16'($urandom),
                     $urandom, 16'($urandom));
    endtask

    task automatic test_directed();
        send_command(MODE_DRAW, 0, 0, 0, 0, 0);                 // empty tree
        send_command(MODE_UNUSED, 63, 16'hFFFF, 16'hFFFF, '1, '1);
        send_command(MODE_ADD_NODE, 0, 0, 16'h0000, 0, 0);      // degree 0 node
        send_command(MODE_SET_WEIGHT, 0, 16'hFFFF, 0, 0, 0);
        send_command(MODE_DRAW, 0, 0, 0, '1, '1);               // still empty
        send_command(MODE_SET_WEIGHT, 63, 16'hFFFF, 0, 0, 0);
        send_command(MODE_ADD_NODE, 63, 0, 16'hFFFF, 0, 0);
        send_command(MODE_ADD_NODE, 63, 0, 16'h5A5A, 0, 0);
        send_command(MODE_SET_WEIGHT, 1, 16'h0001, 0, 0, 0);
        send_command(MODE_ADD_NODE, 1, 0, 16'h1234, 0, 0);
        send_command(MODE_DRAW, 0, 0, 0, 32'h0000_0000, 16'hFFFF);
        send_command(MODE_DRAW, 0, 0, 0, 32'hFFFF_FFFF, 16'h0000);
        send_command(MODE_DRAW, 0, 0, 0, 32'h8000_0000, 16'h0001);
        send_command(MODE_DRAW, 0, 0, 0, 32'h0, 16'h0);         // tree is empty by now
        // fill one bucket to its cap, then overflow it
        send_command(MODE_SET_WEIGHT, 2, 16'hFFFF, 0, 0, 0);
        repeat (CAP) send_command(MODE_ADD_NODE, 2, 0, 16'($urandom), 0, 0);
        send_command(MODE_ADD_NODE, 2, 0, 16'hAAAA, 0, 0);
        repeat (CAP) draw_random();
    endtask

    task automatic test_random(int n);
        int k;
        int sel;
        for (k = 0; k < n; k++)
        begin
            sel = $urandom_range(99, 0);
            if (sel < 15)
                send_command(MODE_SET_WEIGHT, $urandom_range(63, 0),
                             ($urandom_range(3, 0) == 0) ? 16'hFFFF : 16'($urandom),
                             16'($urandom), $urandom, 16'($urandom));
            else if (sel < 55)
                send_command(MODE_ADD_NODE, $urandom_range(63, 0), 16'($urandom),
                             16'($urandom), $urandom, 16'($urandom));
            else if (sel < 97)
                draw_random();
            else
                send_command(MODE_UNUSED, $urandom_range(63, 0), 16'($urandom),
                             16'($urandom), $urandom, 16'($urandom));
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            test_random(20);
        join
    endtask

    initial
    begin
        int i;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        error_count = 0;
        draws_ok = 0;
        draws_empty = 0;
        adds_full = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
        quiet_cycles = 0;
        greedy = 1'b0;
        for (i = 1; i < 2*NDEG; i++)
            tree_sum[i] = '0;
        for (i = 0; i < NDEG; i++)
        begin
            deg_weight[i] = '0;
            deg_count[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        write_greedy(1'b0);
        test_directed();
        test_random(300);
        send_idle_pct = 87;
        test_random(150);
        write_greedy(1'b1);
        send_idle_pct = 0;
        recv_stall_pct = 87;
        test_random(200);
        send_idle_pct = 10;
        recv_stall_pct = 10;
        test_random(150);
        write_greedy(1'b0);
        test_backpressure();
        test_random(50);
        drain();

        $display("Covered set/add/draw/unused commands in both descent modes: %0d draws, %0d empty,",
                 draws_ok, draws_empty);
        $display("%0d full-bucket adds, long receiver hold-off with input stall", adds_full);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
